@@ design/tsphp_pkg.sv @@
`default_nettype none

package tsphp_pkg;

    localparam int PACKET_BYTES = 188;
    localparam int POS_W        = $clog2(PACKET_BYTES);
    localparam int OFS_W        = 10;
    localparam int ACC_W        = 24;
    localparam int MAX_RECS     = 5;
    localparam int REC_IDX_W    = $clog2(MAX_RECS + 1);

    localparam logic [7:0]       SYNC_BYTE    = 8'h47;
    localparam logic [OFS_W-1:0] HEADER_BYTES = 10'd4;

    typedef enum logic [4:0] {
        FC_ERR       = 5'd0,
        FC_PUSI      = 5'd1,
        FC_PRIO      = 5'd2,
        FC_PID       = 5'd3,
        FC_SCRAMBLE  = 5'd4,
        FC_ADAPT_CTL = 5'd5,
        FC_CC        = 5'd6,
        FC_AF_FLAGS  = 5'd7,
        FC_OFFSET    = 5'd8,
        FC_TABLE_ID  = 5'd9,
        FC_SECT_LEN  = 5'd10,
        FC_TSID      = 5'd11,
        FC_VERSION   = 5'd12,
        FC_CUR_NEXT  = 5'd13,
        FC_PROG_NUM  = 5'd14,
        FC_MAP_PID   = 5'd15,
        FC_CRC       = 5'd16,
        FC_STATUS    = 5'd17
    } field_code_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_start;
    } in_t;

    typedef struct packed {
        field_code_t field_code;
        logic [31:0] field_value;
        logic        last_of_byte;
    } out_t;

    typedef struct packed {
        logic ofs_final;
        logic adapt;
        logic payload;
        logic pusi;
    } hdr_flags_t;

endpackage

`default_nettype wire

@@ design/ts_packet_header_pat_parser_unit.sv @@
`default_nettype none

// channel   ports                               payload
// input     s_valid / s_ready / s_data          tsphp_pkg::in_t  (data_byte, packet_start)
// result    m_valid / m_ready / m_data          tsphp_pkg::out_t (field_code, field_value,
//                                                                 last_of_byte)
//
// Each byte is parsed in the cycle it is transferred; its records (0 to 4) land in a
// small record buffer that drains one record per cycle while m_ready is high. A byte
// with at most one record sustains one byte per cycle while m_ready is high; with more,
// the next byte is taken while the last buffered record is being transferred out.
// Synchronous active-low reset clears parser state and empties the buffer.

module ts_packet_header_pat_parser_unit (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire tsphp_pkg::in_t   s_data,
    output logic                  m_valid,
    input  wire                   m_ready,
    output tsphp_pkg::out_t       m_data
);

    logic [tsphp_pkg::POS_W-1:0]     pos_reg, pos_next, pos;
    tsphp_pkg::hdr_flags_t           hf_reg, hf_next;
    logic [12:0]                     pid_reg, pid_next;
    logic [7:0]                      alen_reg, alen_next;
    logic [tsphp_pkg::OFS_W-1:0]     pso_reg, pso_next;
    logic [2:0]                      status_reg, status_next;
    logic [tsphp_pkg::ACC_W-1:0]     acc_reg, acc_next;

    tsphp_pkg::out_t                 qbuf_reg [tsphp_pkg::MAX_RECS];
    logic [tsphp_pkg::REC_IDX_W-1:0] cnt_reg, head_reg;

    tsphp_pkg::out_t                 recs [tsphp_pkg::MAX_RECS];
    logic [tsphp_pkg::REC_IDX_W-1:0] n;
    logic [7:0]                      b;
    logic [tsphp_pkg::OFS_W-1:0]     pos_w, k;
    logic                            s_xfer, m_xfer;

    function automatic tsphp_pkg::out_t mk_rec(tsphp_pkg::field_code_t code,
                                               logic [31:0] value);
        tsphp_pkg::out_t r;
        r.field_code   = code;
        r.field_value  = value;
        r.last_of_byte = 1'b0;
        return r;
    endfunction

    assign s_xfer  = s_valid && s_ready;
    assign m_xfer  = m_valid && m_ready;
    assign m_valid = (cnt_reg != '0);
    assign s_ready = (cnt_reg == '0) || ((cnt_reg == tsphp_pkg::REC_IDX_W'(1)) && m_ready);
    assign m_data  = qbuf_reg[head_reg];

    always_comb begin
        b           = s_data.data_byte;
        pos         = s_data.packet_start ? '0 : pos_reg;
        pos_w       = tsphp_pkg::OFS_W'(pos);
        k           = pos_w - pso_reg;
        hf_next     = hf_reg;
        pid_next    = pid_reg;
        alen_next   = alen_reg;
        pso_next    = pso_reg;
        status_next = status_reg;
        acc_next    = acc_reg;
        n           = '0;
        for (int i = 0; i < tsphp_pkg::MAX_RECS; i++) begin
            recs[i] = mk_rec(tsphp_pkg::FC_ERR, '0);
        end

        if (pos == '0) begin
            hf_next     = '0;
            pid_next    = '0;
            alen_next   = '0;
            pso_next    = tsphp_pkg::HEADER_BYTES;
            acc_next    = '0;
            status_next = {2'b00, b != tsphp_pkg::SYNC_BYTE};
        end else if (!status_reg[0]) begin
            if (pos == tsphp_pkg::POS_W'(1)) begin
                recs[n] = mk_rec(tsphp_pkg::FC_ERR, {31'd0, b[7]});  n = n + 1'b1;
                recs[n] = mk_rec(tsphp_pkg::FC_PUSI, {31'd0, b[6]}); n = n + 1'b1;
                recs[n] = mk_rec(tsphp_pkg::FC_PRIO, {31'd0, b[5]}); n = n + 1'b1;
                if (b[6]) begin
                    hf_next.pusi = 1'b1;
                end
                pid_next = {8'd0, b[4:0]};
            end else if (pos == tsphp_pkg::POS_W'(2)) begin
                pid_next = {pid_reg[4:0], b};
                recs[n] = mk_rec(tsphp_pkg::FC_PID, {19'd0, pid_reg[4:0], b}); n = n + 1'b1;
            end else if (pos == tsphp_pkg::POS_W'(3)) begin
                recs[n] = mk_rec(tsphp_pkg::FC_SCRAMBLE, {30'd0, b[7:6]});  n = n + 1'b1;
                recs[n] = mk_rec(tsphp_pkg::FC_ADAPT_CTL, {30'd0, b[5:4]}); n = n + 1'b1;
                recs[n] = mk_rec(tsphp_pkg::FC_CC, {28'd0, b[3:0]});        n = n + 1'b1;
                if (b[4]) begin
                    hf_next.payload = 1'b1;
                end
                if (b[5]) begin
                    hf_next.adapt = 1'b1;
                end else begin
                    pso_next = tsphp_pkg::HEADER_BYTES;
                    if (!hf_reg.pusi) begin
                        hf_next.ofs_final = 1'b1;
                        recs[n] = mk_rec(tsphp_pkg::FC_OFFSET,
                                         32'(tsphp_pkg::HEADER_BYTES));
                        n = n + 1'b1;
                    end
                end
            end else if (pos == tsphp_pkg::POS_W'(4) && hf_reg.adapt) begin
                alen_next = b;
                pso_next  = tsphp_pkg::HEADER_BYTES + 10'd1 + {2'b00, b};
                if (!hf_reg.pusi) begin
                    hf_next.ofs_final = 1'b1;
                    recs[n] = mk_rec(tsphp_pkg::FC_OFFSET,
                                     32'(tsphp_pkg::HEADER_BYTES + 10'd1 + {2'b00, b}));
                    n = n + 1'b1;
                end
            end else begin
                if (pos == tsphp_pkg::POS_W'(5) && hf_reg.adapt && alen_reg != '0) begin
                    recs[n] = mk_rec(tsphp_pkg::FC_AF_FLAGS, {24'd0, b}); n = n + 1'b1;
                end
                if (!hf_reg.ofs_final) begin
                    // pointer field: payload starts after it
                    if (hf_reg.pusi && pos_w == pso_reg) begin
                        pso_next = pos_w + 10'd1 + {2'b00, b};
                        hf_next.ofs_final = 1'b1;
                        recs[n] = mk_rec(tsphp_pkg::FC_OFFSET,
                                         32'(pos_w + 10'd1 + {2'b00, b}));
                        n = n + 1'b1;
                    end
                end else if (hf_reg.payload && pid_reg == '0 && pos_w >= pso_reg) begin
                    case (k)
                        10'd0: begin
                            recs[n] = mk_rec(tsphp_pkg::FC_TABLE_ID, {24'd0, b});
                            n = n + 1'b1;
                        end
                        10'd1: begin
                            if (!b[7]) begin
                                status_next[1] = 1'b1;
                            end
                            if (b[6]) begin
                                status_next[2] = 1'b1;
                            end
                            acc_next = {20'd0, b[3:0]};
                        end
                        10'd2: begin
                            recs[n] = mk_rec(tsphp_pkg::FC_SECT_LEN, {acc_reg, b});
                            n = n + 1'b1;
                        end
                        10'd3, 10'd8, 10'd12: begin
                            acc_next = {16'd0, b};
                        end
                        10'd4: begin
                            recs[n] = mk_rec(tsphp_pkg::FC_TSID, {acc_reg, b});
                            n = n + 1'b1;
                        end
                        10'd5: begin
                            recs[n] = mk_rec(tsphp_pkg::FC_VERSION, {27'd0, b[5:1]});
                            n = n + 1'b1;
                            recs[n] = mk_rec(tsphp_pkg::FC_CUR_NEXT, {31'd0, b[0]});
                            n = n + 1'b1;
                        end
                        10'd9: begin
                            recs[n] = mk_rec(tsphp_pkg::FC_PROG_NUM, {acc_reg, b});
                            n = n + 1'b1;
                        end
                        10'd10: begin
                            acc_next = {19'd0, b[4:0]};
                        end
                        10'd11: begin
                            recs[n] = mk_rec(tsphp_pkg::FC_MAP_PID, {acc_reg, b});
                            n = n + 1'b1;
                        end
                        10'd13, 10'd14: begin
                            acc_next = {acc_reg[15:0], b};
                        end
                        10'd15: begin
                            recs[n] = mk_rec(tsphp_pkg::FC_CRC, {acc_reg, b});
                            n = n + 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end

        if (pos == tsphp_pkg::POS_W'(tsphp_pkg::PACKET_BYTES - 1)) begin
            recs[n] = mk_rec(tsphp_pkg::FC_STATUS, {29'd0, status_next});
            n = n + 1'b1;
        end

        for (int i = 0; i < tsphp_pkg::MAX_RECS; i++) begin
            recs[i].last_of_byte = (tsphp_pkg::REC_IDX_W'(i + 1) == n);
        end

        pos_next = (pos >= tsphp_pkg::POS_W'(tsphp_pkg::PACKET_BYTES - 1)) ? '0
                                                                           : pos + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            hf_reg     <= '0;
            pid_reg    <= '0;
            alen_reg   <= '0;
            pso_reg    <= tsphp_pkg::HEADER_BYTES;
            status_reg <= '0;
            acc_reg    <= '0;
            cnt_reg    <= '0;
            head_reg   <= '0;
        end else begin
            if (s_xfer) begin
                pos_reg    <= pos_next;
                hf_reg     <= hf_next;
                pid_reg    <= pid_next;
                alen_reg   <= alen_next;
                pso_reg    <= pso_next;
                status_reg <= status_next;
                acc_reg    <= acc_next;
                cnt_reg    <= n;
                head_reg   <= '0;
            end else if (m_xfer) begin
                cnt_reg    <= cnt_reg - 1'b1;
                head_reg   <= head_reg + 1'b1;
            end
        end
    end

    // record buffer payload, loaded whole on each byte transfer
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            for (int i = 0; i < tsphp_pkg::MAX_RECS; i++) begin
                qbuf_reg[i] <= recs[i];
            end
        end
    end

endmodule

`default_nettype wire

@@ tb/sv/tsphp_record_checker.sv @@
module tsphp_record_checker (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_valid,
    input  wire              s_ready,
    input  tsphp_pkg::in_t   s_data,
    input  wire              m_valid,
    input  wire              m_ready,
    input  tsphp_pkg::out_t  m_data,
    output int               due_count,
    output int               mismatches
);
    import tsphp_pkg::*;

    // parser state mirror
    logic [7:0]  pkt_pos;
    hdr_flags_t  hdr;
    logic [12:0] pid_q;
    logic [7:0]  af_len;
    logic [9:0]  pl_ofs;
    logic [2:0]  status_q;
    logic [31:0] acc;

    out_t records_due[$];
    out_t byte_recs[$];

    initial begin
        mismatches = 0;
        due_count  = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic void note_field(input field_code_t c, input logic [31:0] v);
        out_t r;
        r.field_code   = c;
        r.field_value  = v;
        r.last_of_byte = 1'b0;
        byte_recs = {byte_recs, r};
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic st);
        logic [7:0] p;
        logic [1:0] ctl;
        int         k;
        out_t       tail;
        p = st ? 8'd0 : pkt_pos;
        byte_recs.delete();
        if (p == 8'd0) begin
            hdr      = '0;
            pid_q    = '0;
            af_len   = '0;
            pl_ofs   = HEADER_BYTES;
            acc      = '0;
            status_q = (b != SYNC_BYTE) ? 3'b001 : 3'b000;
        end else if (!status_q[0]) begin
            if (p == 8'd1) begin
                note_field(FC_ERR, 32'(b[7]));
                note_field(FC_PUSI, 32'(b[6]));
                note_field(FC_PRIO, 32'(b[5]));
                if (b[6]) hdr.pusi = 1'b1;
                pid_q = {8'd0, b[4:0]};
            end else if (p == 8'd2) begin
                pid_q = {pid_q[4:0], b};
                note_field(FC_PID, 32'(pid_q));
            end else if (p == 8'd3) begin
                ctl = b[5:4];
                note_field(FC_SCRAMBLE, 32'(b[7:6]));
                note_field(FC_ADAPT_CTL, 32'(ctl));
                note_field(FC_CC, 32'(b[3:0]));
                if (ctl[0]) hdr.payload = 1'b1;
                if (ctl[1]) begin
                    hdr.adapt = 1'b1;
                end else begin
                    pl_ofs = HEADER_BYTES;
                    if (!hdr.pusi) begin
                        hdr.ofs_final = 1'b1;
                        note_field(FC_OFFSET, 32'(HEADER_BYTES));
                    end
                end
            end else if (p == 8'd4 && hdr.adapt) begin
                af_len = b;
                pl_ofs = 10'd5 + {2'b00, b};
                if (!hdr.pusi) begin
                    hdr.ofs_final = 1'b1;
                    note_field(FC_OFFSET, 32'(pl_ofs));
                end
            end else begin
                if (p == 8'd5 && hdr.adapt && af_len != 8'd0)
                    note_field(FC_AF_FLAGS, 32'(b));
                if (!hdr.ofs_final) begin
                    // pointer field sits at the offset when unit start is set
                    if (hdr.pusi && {2'b00, p} == pl_ofs) begin
                        pl_ofs = {2'b00, p} + 10'd1 + {2'b00, b};
                        hdr.ofs_final = 1'b1;
                        note_field(FC_OFFSET, 32'(pl_ofs));
                    end
                end else if (hdr.payload && pid_q == 13'd0 && {2'b00, p} >= pl_ofs) begin
                    k = int'(p) - int'(pl_ofs);
                    case (k)
                        0: note_field(FC_TABLE_ID, 32'(b));
                        1: begin
                            if (!b[7]) status_q[1] = 1'b1;
                            if (b[6])  status_q[2] = 1'b1;
                            acc = {28'd0, b[3:0]};
                        end
                        2: note_field(FC_SECT_LEN, {acc[23:0], b});
                        3: acc = {24'd0, b};
                        4: note_field(FC_TSID, {acc[23:0], b});
                        5: begin
                            note_field(FC_VERSION, 32'(b[5:1]));
                            note_field(FC_CUR_NEXT, 32'(b[0]));
                        end
                        8: acc = {24'd0, b};
                        9: note_field(FC_PROG_NUM, {acc[23:0], b});
                        10: acc = {27'd0, b[4:0]};
                        11: note_field(FC_MAP_PID, {acc[23:0], b});
                        12: acc = {24'd0, b};
                        13, 14: acc = {acc[23:0], b};
                        15: note_field(FC_CRC, {acc[23:0], b});
                        default: ;
                    endcase
                end
            end
        end
        if (int'(p) == PACKET_BYTES - 1)
            note_field(FC_STATUS, 32'(status_q));
        if (byte_recs.size() > 0) begin
            tail = byte_recs[byte_recs.size() - 1];
            tail.last_of_byte = 1'b1;
            byte_recs[byte_recs.size() - 1] = tail;
        end
        foreach (byte_recs[i]) records_due = {records_due, byte_recs[i]};
        pkt_pos = (int'(p) + 1 >= PACKET_BYTES) ? 8'd0 : p + 8'd1;
    endtask

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            pkt_pos  = '0;
            hdr      = '0;
            pid_q    = '0;
            af_len   = '0;
            pl_ofs   = HEADER_BYTES;
            status_q = '0;
            acc      = '0;
            records_due.delete();
        end else begin
            // predict before checking; records of this byte are registered and leave in the next cycle at the earliest
            if (s_valid && s_ready)
                parse_byte(s_data.data_byte, s_data.packet_start);
            if (m_valid && m_ready) begin
                if (records_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected record code %0d value %0h",
                                              m_data.field_code, m_data.field_value));
                end else begin
                    want = records_due.pop_front();
                    if (m_data.field_code !== want.field_code)
                        report_mismatch($sformatf("field_code got %0d want %0d",
                                                  m_data.field_code, want.field_code));
                    if (m_data.field_value !== want.field_value)
                        report_mismatch($sformatf("field_value (code %0d) got %0h want %0h",
                                                  want.field_code, m_data.field_value,
                                                  want.field_value));
                    if (m_data.last_of_byte !== want.last_of_byte)
                        report_mismatch($sformatf("last_of_byte (code %0d) got %0b want %0b",
                                                  want.field_code, m_data.last_of_byte,
                                                  want.last_of_byte));
                end
            end
        end
        due_count <= records_due.size();
    end

endmodule

@@ tb/sv/ts_packet_header_pat_parser_unit_tb.sv @@
module ts_packet_header_pat_parser_unit_tb;
    import tsphp_pkg::*;

    localparam int RANDOM_ITEMS = 270;

    logic  aclk    = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    in_t   s_data  = '0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    out_t  m_data;

    int    due_count;
    int    mismatches;
    int    tx_idle_pct  = 0;
    int    rx_stall_pct = 0;
    int    n_sent       = 0;

    ts_packet_header_pat_parser_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    tsphp_record_checker u_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .due_count  (due_count),
        .mismatches (mismatches)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic put_byte(input logic [7:0] b, input logic st);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{data_byte: b, packet_start: st};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_sent++;
    endtask

    // one packet, mostly with a plausible header/PAT layout (else noise), random content, often cut short
    task automatic send_packet(input logic marked, input bit make_full, output bit full);
        logic [7:0] pkt [PACKET_BYTES];
        int         ofs;
        int         len;
        int         roll;
        logic [7:0] ptr;
        foreach (pkt[i]) pkt[i] = 8'($urandom);
        if ($urandom_range(99) < 5) begin
            // noise
            len = $urandom_range(1, 30);
        end else begin
            if ($urandom_range(99) >= 8) pkt[0] = SYNC_BYTE;
            if ($urandom_range(99) < 65) begin
                pkt[1][4:0] = 5'd0;
                pkt[2]      = 8'd0;
            end
            ofs = 4;
            if (pkt[3][5]) begin
                roll = $urandom_range(99);
                if (roll < 25)      pkt[4] = 8'd0;
                else if (roll < 85) pkt[4] = 8'($urandom_range(1, 6));
                ofs = 5 + pkt[4];
            end
            if (pkt[1][6] && ofs < PACKET_BYTES) begin
                roll = $urandom_range(99);
                if (roll < 60)      ptr = 8'd0;
                else if (roll < 90) ptr = 8'($urandom_range(1, 3));
                else                ptr = pkt[ofs];
                pkt[ofs] = ptr;
                ofs = ofs + 1 + ptr;
            end
            // section syntax byte: mostly well formed
            if (ofs + 1 < PACKET_BYTES)
                pkt[ofs + 1][7:6] = {($urandom_range(9) != 0), ($urandom_range(9) == 0)};
            len = ofs + $urandom_range(12, 20);
            if ($urandom_range(99) < 15) len = PACKET_BYTES;
        end
        if (make_full) len = PACKET_BYTES;
        if (len > PACKET_BYTES) len = PACKET_BYTES;
        full = (len == PACKET_BYTES);
        for (int i = 0; i < len; i++)
            put_byte(pkt[i], (i == 0) ? marked : 1'b0);
    endtask

    initial begin
        logic [7:0] directed [25];
        bit         was_full;
        int         pkt_idx;
        int         quiet;
        directed = '{
            8'h47, 8'hE0, 8'h00, 8'hFF, 8'h00, 8'h00,
            8'hFF, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00,
            8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
            8'h00, 8'hFF, 8'hFF
        };
        pkt_idx  = 0;
        was_full = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: a PAT packet cut short after its CRC, then a truncated one with bad sync
        for (int i = 0; i < 25; i++)
            put_byte(directed[i], (i == 0 || i == 22) ? 1'b1 : 1'b0);

        // first random packet runs to full length so a status record is always seen
        while (n_sent < RANDOM_ITEMS) begin
            case (pkt_idx % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 50; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 50; end
                default: begin tx_idle_pct = 18; rx_stall_pct = 18; end
            endcase
            // after a complete packet the position wraps, so the marker is optional
            send_packet(was_full ? 1'($urandom_range(1)) : 1'b1, pkt_idx == 0, was_full);
            pkt_idx++;
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (due_count != 0) @(posedge aclk);
        quiet = 0;
        while (quiet < 20) begin
            @(posedge aclk);
            quiet++;
        end
        if (mismatches == 0 && due_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
